// ----- sv/crcfb_pkg.sv -----
// Package for the CRC-16 frame builder: framing constants, request and status
// codes, the result word type and the byte-wide CRC-16/MODBUS update.
// No dependencies.
package crcfb_pkg;

    // Frame framing and CRC constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  SYNC_A   = 8'h55;
    localparam logic [7:0]  SYNC_B   = 8'hAA;

    // Request type codes.
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    // One result word as it travels to the output register.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_run;
        logic       end_of_frame;
        logic       status;
    } t_result;

    // Folds one byte into the reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/crcfb_seq.sv -----
// Word sequencer of the CRC-16 frame builder: holds the accepted request,
// keeps the frame state and produces one result word per cycle while it is taken.
// Depends on crcfb_pkg.
module crcfb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_req_type,
    input  logic [7:0]           i_fun_code,
    input  logic [15:0]          i_frame_length,
    input  logic [7:0]           i_payload_byte,
    output logic                 o_res_valid,
    output crcfb_pkg::t_result   o_res,
    input  logic                 i_res_take
);
    import crcfb_pkg::*;

    // Word positions within one request's run.
    localparam logic [2:0] IDX_FIRST   = 3'd0;
    localparam logic [2:0] IDX_LEN_LO  = 3'd4;
    localparam logic [2:0] IDX_CRC_HI  = 3'd5;
    localparam logic [2:0] IDX_CRC_LO  = 3'd6;
    localparam logic [2:0] IDX_PCRC_HI = 3'd1;
    localparam logic [2:0] IDX_PCRC_LO = 3'd2;

    // Held request.
    logic        r_in_valid, n_in_valid;
    logic        r_req;
    logic [7:0]  r_fc;
    logic [15:0] r_len;
    logic [7:0]  r_pb;
    logic [2:0]  r_idx, n_idx;

    // Frame state.
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_left, n_left;
    logic        r_open, n_open;

    t_result     res;
    logic        is_data;
    logic [15:0] crc_base;
    logic        fire;
    logic        done;
    logic        accept;

    // Result word for the current position of the held request.
    always_comb begin
        res      = '{tx_byte: 8'h00, last_of_run: 1'b0, end_of_frame: 1'b0,
                     status: STATUS_OK};
        is_data  = 1'b0;
        crc_base = r_crc;
        case (r_req)
            REQ_HEADER: begin
                crc_base = (r_idx == IDX_FIRST) ? CRC_INIT : r_crc;
                is_data  = (r_idx <= IDX_LEN_LO);
                case (r_idx)
                    IDX_FIRST:  res.tx_byte = SYNC_A;
                    3'd1:       res.tx_byte = SYNC_B;
                    3'd2:       res.tx_byte = r_fc;
                    3'd3:       res.tx_byte = r_len[15:8];
                    IDX_LEN_LO: res.tx_byte = r_len[7:0];
                    IDX_CRC_HI: res.tx_byte = r_crc[15:8];
                    default:    res.tx_byte = r_crc[7:0];
                endcase
                res.end_of_frame = (r_idx == IDX_CRC_LO);
                res.last_of_run  = (r_len == 16'd0) ? (r_idx == IDX_CRC_LO)
                                                    : (r_idx == IDX_LEN_LO);
            end
            default: begin
                if (!r_open) begin
                    // Payload word with no frame open: dropped and flagged.
                    res.last_of_run = 1'b1;
                    res.status      = STATUS_DROP;
                end else begin
                    is_data = (r_idx == IDX_FIRST);
                    case (r_idx)
                        IDX_FIRST:   res.tx_byte = r_pb;
                        IDX_PCRC_HI: res.tx_byte = r_crc[15:8];
                        default:     res.tx_byte = r_crc[7:0];
                    endcase
                    res.end_of_frame = (r_idx == IDX_PCRC_LO);
                    res.last_of_run  = (r_left == 16'd1) ? (r_idx == IDX_PCRC_LO)
                                                         : (r_idx == IDX_FIRST);
                end
            end
        endcase
    end

    assign fire       = r_in_valid && i_res_take;
    assign done       = fire && res.last_of_run;
    assign o_in_ready = !r_in_valid || done;
    assign accept     = i_in_valid && o_in_ready;

    // Next-state logic for the held request and the frame state.
    always_comb begin
        n_in_valid = r_in_valid;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_left     = r_left;
        n_open     = r_open;
        if (fire) begin
            n_idx = done ? IDX_FIRST : r_idx + 3'd1;
            if (is_data) begin
                n_crc = crc_update(crc_base, res.tx_byte);
            end
            if (res.end_of_frame) begin
                n_crc = CRC_INIT;
            end
        end
        if (done) begin
            n_in_valid = 1'b0;
            if (r_req == REQ_HEADER) begin
                n_open = (r_len != 16'd0);
                n_left = r_len;
            end else if (r_open) begin
                n_left = r_left - 16'd1;
                n_open = (r_left != 16'd1);
            end
        end
        if (accept) begin
            n_in_valid = 1'b1;
        end
    end

    // Control and frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= IDX_FIRST;
            r_crc      <= CRC_INIT;
            r_left     <= 16'd0;
            r_open     <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_idx      <= n_idx;
            r_crc      <= n_crc;
            r_left     <= n_left;
            r_open     <= n_open;
        end
    end

    // Request payload register, loaded on acceptance.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req_type;
            r_fc  <= i_fun_code;
            r_len <= i_frame_length;
            r_pb  <= i_payload_byte;
        end
    end

    assign o_res_valid = r_in_valid;
    assign o_res       = res;

endmodule

// ----- sv/crcfb_outreg.sv -----
// Output register of the CRC-16 frame builder: holds one result word until
// the downstream side takes it. Depends on crcfb_pkg.
module crcfb_outreg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_res_valid,
    input  crcfb_pkg::t_result   i_res,
    output logic                 o_res_take,
    output logic                 o_out_valid,
    output crcfb_pkg::t_result   o_res,
    input  logic                 i_out_ready
);
    import crcfb_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    take;

    // The register loads whenever it is empty or being emptied.
    assign take = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_res_take  = take;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

// ----- sv/crc16_frame_builder.sv -----
// CRC-16/MODBUS frame builder. A request is registered on acceptance and its
// words then pass through the output register. A payload request yields one
// word (three when it closes the frame), a header five words (seven for a
// zero-length frame); the output register moves one word per cycle while
// i_out_ready is high. Reset (synchronous, active low) empties both registers,
// closes any frame and sets the CRC to 0xFFFF.
module crc16_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_fun_code,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_payload_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_frame,
    output logic        o_status
);
    import crcfb_pkg::*;

    logic    w_res_valid;
    t_result w_res;
    logic    w_res_take;
    t_result w_out;

    // Request holding, frame state and word generation.
    crcfb_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_fun_code     (i_fun_code),
        .i_frame_length (i_frame_length),
        .i_payload_byte (i_payload_byte),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res),
        .i_res_take     (w_res_take)
    );

    // Output register.
    crcfb_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_res_take  (w_res_take),
        .o_out_valid (o_out_valid),
        .o_res       (w_out),
        .i_out_ready (i_out_ready)
    );

    assign o_tx_byte      = w_out.tx_byte;
    assign o_last_of_run  = w_out.last_of_run;
    assign o_end_of_frame = w_out.end_of_frame;
    assign o_status       = w_out.status;

    // The final CRC word always ends its request's run.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_last_of_run)
        else $error("end of frame without end of run");

    // A dropped payload word is a lone zero word that closes no frame.
    a_drop_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_DROP) |->
            (o_last_of_run && !o_end_of_frame && o_tx_byte == 8'h00))
        else $error("malformed drop word");

    // A held request that cannot move blocks new requests.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_res_take) |-> !o_in_ready)
        else $error("request accepted while the held one is stalled");

endmodule

// ----- sim/crcfb_frame_check.sv -----
// Checker for the CRC-16 frame builder: watches both word channels, predicts
// the frame bytes of every accepted request and compares them in order.
// Depends on crcfb_pkg for the result word type, codes and constants.
module crcfb_frame_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_fun_code,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last_of_run,
    input  logic        i_end_of_frame,
    input  logic        i_status,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import crcfb_pkg::*;

    // Predicted framer state and the frame bytes still owed by the block.
    logic [15:0] frame_crc;
    logic [15:0] bytes_to_go;
    logic        frame_live;
    t_result     owed_words[$];
    int          words_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        words_seen   = 0;
        frame_crc    = CRC_INIT;
        bytes_to_go  = '0;
        frame_live   = 1'b0;
    end

    // Reflected CRC-16 folded in one data bit at a time.
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic owe_word(input logic [7:0] b, input logic last, input logic eof,
                            input logic st);
        t_result w;
        w.tx_byte      = b;
        w.last_of_run  = last;
        w.end_of_frame = eof;
        w.status       = st;
        owed_words.push_back(w);
    endtask

    // A frame byte goes out and is folded into the running CRC.
    task automatic owe_frame_byte(input logic [7:0] b, input logic last);
        owe_word(b, last, 1'b0, STATUS_OK);
        frame_crc = crc16_fold(frame_crc, b);
    endtask

    // The two CRC bytes close the frame, high byte first.
    task automatic owe_crc_and_close();
        owe_word(frame_crc[15:8], 1'b0, 1'b0, STATUS_OK);
        owe_word(frame_crc[7:0], 1'b1, 1'b1, STATUS_OK);
        frame_live  = 1'b0;
        bytes_to_go = '0;
        frame_crc   = CRC_INIT;
    endtask

    // Works out the bytes that one accepted request word gives rise to.
    task automatic predict_frame_bytes(input logic req, input logic [7:0] fc,
                                       input logic [15:0] len, input logic [7:0] pb);
        if (req == REQ_HEADER) begin
            // A header always restarts the CRC, abandoning any open frame.
            frame_crc = CRC_INIT;
            owe_frame_byte(SYNC_A, 1'b0);
            owe_frame_byte(SYNC_B, 1'b0);
            owe_frame_byte(fc, 1'b0);
            owe_frame_byte(len[15:8], 1'b0);
            owe_frame_byte(len[7:0], len != 16'd0);
            if (len == 16'd0) begin
                owe_crc_and_close();
            end else begin
                frame_live  = 1'b1;
                bytes_to_go = len;
            end
        end else if (!frame_live) begin
            // A stray payload byte is dropped and flagged.
            owe_word(8'h00, 1'b1, 1'b0, STATUS_DROP);
        end else begin
            bytes_to_go = bytes_to_go - 16'd1;
            owe_frame_byte(pb, bytes_to_go != 16'd0);
            if (bytes_to_go == 16'd0) begin
                owe_crc_and_close();
            end
        end
    endtask

    task automatic note_failure(input string what, input t_result want,
                                input t_result got);
        if (o_fail_count < 10) begin
            $write("%0t: output word %0d %s: expected byte %02h last %b eof %b status %b,",
                   $time, words_seen, what, want.tx_byte, want.last_of_run,
                   want.end_of_frame, want.status);
            $display(" got byte %02h last %b eof %b status %b",
                     got.tx_byte, got.last_of_run, got.end_of_frame, got.status);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    // Outputs are compared before new requests are predicted at each edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            frame_crc   = CRC_INIT;
            bytes_to_go = '0;
            frame_live  = 1'b0;
            owed_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.tx_byte      = i_tx_byte;
                got.last_of_run  = i_last_of_run;
                got.end_of_frame = i_end_of_frame;
                got.status       = i_status;
                if (owed_words.size() == 0) begin
                    note_failure("with nothing expected", '0, got);
                end else begin
                    want = owed_words.pop_front();
                    if (got.tx_byte !== want.tx_byte ||
                        got.last_of_run !== want.last_of_run ||
                        got.end_of_frame !== want.end_of_frame ||
                        got.status !== want.status) begin
                        note_failure("mismatch", want, got);
                    end
                end
                words_seen = words_seen + 1;
            end
            if (i_in_valid && i_in_ready) begin
                predict_frame_bytes(i_req_type, i_fun_code, i_frame_length,
                                    i_payload_byte);
            end
        end
        o_pending = owed_words.size();
    end

endmodule

// ----- sim/crc16_frame_builder_test.sv -----
// Testbench top for the CRC-16 frame builder: drives directed and random
// request words with random idling on both channels and gives the verdict.
// Depends on crcfb_pkg, crc16_frame_builder and crcfb_frame_check.
module crc16_frame_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfb_pkg::*;

    localparam int DIRECTED_WORDS = 22;
    localparam int RANDOM_WORDS   = 198;
    localparam int STALL_LIMIT    = 2000;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        req_type     = REQ_HEADER;
    logic [7:0]  fun_code     = 8'h00;
    logic [15:0] frame_length = 16'h0000;
    logic [7:0]  payload_byte = 8'h00;
    logic        out_ready    = 1'b0;

    wire         in_ready;
    wire         out_valid;
    wire  [7:0]  tx_byte;
    wire         last_of_run;
    wire         end_of_frame;
    wire         status;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left  = 0;
    int quiet_left  = 0;
    int words_sent  = 0;
    bit quiet_phase = 1'b0;

    crc16_frame_builder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_fun_code     (fun_code),
        .i_frame_length (frame_length),
        .i_payload_byte (payload_byte),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_tx_byte      (tx_byte),
        .o_last_of_run  (last_of_run),
        .o_end_of_frame (end_of_frame),
        .o_status       (status)
    );

    crcfb_frame_check frame_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_req_type     (req_type),
        .i_fun_code     (fun_code),
        .i_frame_length (frame_length),
        .i_payload_byte (payload_byte),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_tx_byte      (tx_byte),
        .i_last_of_run  (last_of_run),
        .i_end_of_frame (end_of_frame),
        .i_status       (status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Quiet stretches in which neither side idles.
    always @(posedge clk) begin
        if (quiet_left == 0) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            quiet_left  = $urandom_range(30, 150);
        end else begin
            quiet_left = quiet_left - 1;
        end
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (quiet_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Receiver stalls.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // Watchdog: counts cycles in which no word moves on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Presents one request word, waits for it to be taken, then maybe idles.
    task automatic drive_word(input logic req, input logic [7:0] fc,
                              input logic [15:0] len, input logic [7:0] pb);
        int gap;
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= req;
        fun_code     <= fc;
        frame_length <= len;
        payload_byte <= pb;
        do begin
            @(posedge clk);
        end while (!in_ready);
        words_sent = words_sent + 1;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Fields that a word does not use carry random values.
    task automatic send_header(input logic [7:0] fc, input logic [15:0] len);
        drive_word(REQ_HEADER, fc, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] pb);
        drive_word(REQ_PAYLOAD, 8'($urandom), 16'($urandom), pb);
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_header(8'($urandom), len);
        repeat (len) send_payload(8'($urandom));
    endtask

    initial begin
        int pick;
        int len_pick;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Stray payload words straight after reset are dropped.
        send_payload(8'hFF);
        send_payload(8'h00);
        // Zero-length frames with extreme function codes.
        send_header(8'h00, 16'h0000);
        send_header(8'hFF, 16'h0000);
        // Shortest frame with payload.
        send_header(8'h03, 16'h0001);
        send_payload(8'hFF);
        // Longest length, abandoned by a new header that then completes.
        send_header(8'h10, 16'hFFFF);
        send_payload(8'h00);
        send_payload(8'hA5);
        send_header(8'h5A, 16'h0002);
        send_payload(8'h12);
        send_payload(8'h34);
        // Stray word once the frame has closed.
        send_payload(8'h77);
        // Open frame abandoned by a zero-length header.
        send_header(8'h81, 16'h8000);
        send_header(8'h7E, 16'h0000);
        // Abandon after one payload word, then a three-byte frame.
        send_header(8'h22, 16'h0100);
        send_payload(8'hFF);
        send_header(8'h01, 16'h0003);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h80);
        send_payload(8'h3C);

        // Random part: mostly whole frames, some abandoned, strays and noise.
        while (words_sent < DIRECTED_WORDS + RANDOM_WORDS) begin
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                len_pick = $urandom_range(0, 19);
                if (len_pick == 0) begin
                    send_frame(16'd0);
                end else if (len_pick < 17) begin
                    send_frame(16'($urandom_range(1, 6)));
                end else begin
                    send_frame(16'($urandom_range(7, 24)));
                end
            end else if (pick < 16) begin
                send_header(8'($urandom), 16'($urandom_range(5, 65535)));
                repeat ($urandom_range(0, 4)) send_payload(8'($urandom));
            end else if (pick < 18) begin
                send_payload(8'($urandom));
            end else begin
                drive_word(1'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
                           8'($urandom));
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain, then keep watching for any stray output word.
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/crcfb_pkg.sv
sv/crcfb_seq.sv
sv/crcfb_outreg.sv
sv/crc16_frame_builder.sv
sim/crcfb_frame_check.sv
sim/crc16_frame_builder_test.sv
